// ----- rtl/utfv_pkg.sv -----
// Package: shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package utfv_pkg;

  localparam int unsigned CP_BITS  = 21;
  localparam int unsigned ERR_OFS_BITS = 32;

  localparam logic [7:0] LEAD_MIN = 8'hC2;
  localparam logic [7:0] LEAD_MAX = 8'hF4;
  localparam logic [7:0] CONT_MAX = 8'hBF;

  localparam logic [CP_BITS-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [CP_BITS-1:0] MIN_4BYTE  = 21'h010000;
  localparam logic [CP_BITS-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_BITS-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10FFFF;

  // Sequence length codes (continuation bytes that follow the lead)
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  typedef struct packed {
    logic                    has_code_point;
    logic [CP_BITS-1:0]      code_point;
    logic                    error_now;
    logic [ERR_OFS_BITS-1:0] error_offset;
    logic [7:0]              error_byte;
    logic                    buffer_done;
    logic                    buffer_valid;
  } result_t;

endpackage

// ----- rtl/utfv_decode.sv -----
// Decoder: per-byte UTF-8 state machine and result formation.
`timescale 1ns / 1ps

module utfv_decode #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              has_result,
  output utfv_pkg::result_t result
);

  logic [utfv_pkg::CP_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]                   rem_r, rem_nxt;
  logic [1:0]                   seq_r, seq_nxt;
  logic [7:0]                   lead_val_r, lead_val_nxt;
  logic [OFFSET_BITS-1:0]       lead_ofs_r, lead_ofs_nxt;
  logic [OFFSET_BITS-1:0]       pos_r, pos_nxt;
  logic                         err_seen_r, err_seen_nxt;

  logic [utfv_pkg::CP_BITS-1:0] acc_shift;
  logic [63:0]                  lead_ofs_ext;
  logic                         have_cp, err_now, bad;
  logic [utfv_pkg::CP_BITS-1:0] cp;

  assign acc_shift = {acc_r[utfv_pkg::CP_BITS-7:0], data_byte[5:0]};

  always_comb begin
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    seq_nxt      = seq_r;
    lead_val_nxt = lead_val_r;
    lead_ofs_nxt = lead_ofs_r;
    err_seen_nxt = err_seen_r;
    have_cp      = 1'b0;
    err_now      = 1'b0;
    bad          = 1'b0;
    cp           = '0;

    if (!err_seen_r) begin
      if (rem_r == 2'd0) begin
        lead_ofs_nxt = pos_r;
        lead_val_nxt = data_byte;
        if (!data_byte[7]) begin
          have_cp = 1'b1;
          cp      = utfv_pkg::CP_BITS'(data_byte);
        end else if (data_byte < utfv_pkg::LEAD_MIN || data_byte > utfv_pkg::LEAD_MAX) begin
          err_now = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          acc_nxt = utfv_pkg::CP_BITS'(data_byte[4:0]);
          rem_nxt = utfv_pkg::SEQ_TWO;
          seq_nxt = utfv_pkg::SEQ_TWO;
        end else if (data_byte[7:4] == 4'b1110) begin
          acc_nxt = utfv_pkg::CP_BITS'(data_byte[3:0]);
          rem_nxt = utfv_pkg::SEQ_THREE;
          seq_nxt = utfv_pkg::SEQ_THREE;
        end else begin
          acc_nxt = utfv_pkg::CP_BITS'(data_byte[2:0]);
          rem_nxt = utfv_pkg::SEQ_FOUR;
          seq_nxt = utfv_pkg::SEQ_FOUR;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        err_now = 1'b1;
      end else begin
        acc_nxt = acc_shift;
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          // Range checks happen on the final continuation only
          if (seq_r == utfv_pkg::SEQ_THREE && acc_shift < utfv_pkg::MIN_3BYTE) bad = 1'b1;
          if (seq_r == utfv_pkg::SEQ_FOUR && acc_shift < utfv_pkg::MIN_4BYTE) bad = 1'b1;
          if (acc_shift >= utfv_pkg::SURR_LO && acc_shift <= utfv_pkg::SURR_HI) bad = 1'b1;
          if (acc_shift > utfv_pkg::CP_MAX) bad = 1'b1;
          if (bad) begin
            err_now = 1'b1;
          end else begin
            have_cp = 1'b1;
            cp      = acc_shift;
          end
          seq_nxt = utfv_pkg::SEQ_NONE;
          acc_nxt = '0;
        end
      end
      // Sequence left open by the end of the buffer
      if (!err_now && last_byte && rem_nxt != 2'd0) err_now = 1'b1;
      if (err_now) begin
        err_seen_nxt = 1'b1;
        rem_nxt      = 2'd0;
        seq_nxt      = utfv_pkg::SEQ_NONE;
        acc_nxt      = '0;
      end
    end

    pos_nxt = pos_r + OFFSET_BITS'(1);

    if (last_byte) begin
      acc_nxt      = '0;
      rem_nxt      = 2'd0;
      seq_nxt      = utfv_pkg::SEQ_NONE;
      lead_val_nxt = '0;
      lead_ofs_nxt = '0;
      pos_nxt      = '0;
      err_seen_nxt = 1'b0;
    end
  end

  always_comb begin
    lead_ofs_ext = 64'(err_seen_r ? lead_ofs_r : (rem_r == 2'd0 ? pos_r : lead_ofs_r));
    result.has_code_point = have_cp;
    result.code_point     = cp;
    result.error_now      = err_now;
    result.error_offset   = err_now ? lead_ofs_ext[utfv_pkg::ERR_OFS_BITS-1:0] : '0;
    result.error_byte     = err_now ? ((rem_r == 2'd0) ? data_byte : lead_val_r) : '0;
    result.buffer_done    = last_byte;
    result.buffer_valid   = last_byte && !err_seen_r && !err_now;
    has_result            = have_cp || err_now || last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      rem_r      <= 2'd0;
      seq_r      <= utfv_pkg::SEQ_NONE;
      lead_val_r <= '0;
      lead_ofs_r <= '0;
      pos_r      <= '0;
      err_seen_r <= 1'b0;
    end else if (adv) begin
      acc_r      <= acc_nxt;
      rem_r      <= rem_nxt;
      seq_r      <= seq_nxt;
      lead_val_r <= lead_val_nxt;
      lead_ofs_r <= lead_ofs_nxt;
      pos_r      <= pos_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

  a_rem_within_seq: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= seq_r)
    else $error("bytes remaining exceed sequence length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_byte |=> rem_r == 2'd0 && pos_r == '0 && !err_seen_r)
    else $error("state not cleared after last byte");

  a_idle_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    err_seen_r |-> rem_r == 2'd0 && acc_r == '0)
    else $error("sequence still open after error");

  a_cp_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> !(have_cp && err_now))
    else $error("code point and error on the same byte");

endmodule

// ----- rtl/utfv_out_reg.sv -----
// Result register: holds one result transaction until the consumer takes it.
`timescale 1ns / 1ps

module utfv_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  utfv_pkg::result_t load_data,
  input  logic              out_stall,
  output logic              ready,
  output logic              out_valid,
  output utfv_pkg::result_t out_data
);

  logic              valid_r, valid_nxt;
  utfv_pkg::result_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !load)
    else $error("held result overwritten");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(data_r))
    else $error("stalled result changed");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(data_r.buffer_valid && (data_r.error_now || !data_r.buffer_done)))
    else $error("valid verdict with error or without done");

endmodule

// ----- rtl/utf8_stream_validator_top.sv -----
// Top level: strict UTF-8 stream decoder and validator, one byte per clock.
// Path: an accepted byte passes through the input register and then the result register,
//   which drives its result transaction (if any) onto the output ports.
// Throughput: one byte per cycle, sustained while the output is not stalled.
// Reset: synchronous active-low rst_n empties both registers and clears decode state.
`timescale 1ns / 1ps

module utf8_stream_validator_top #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel: one raw byte per transaction
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_last_byte,
  // Result channel: code point, first error and buffer verdict
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_has_code_point,
  output logic [utfv_pkg::CP_BITS-1:0]         out_code_point,
  output logic                                 out_error_now,
  output logic [utfv_pkg::ERR_OFS_BITS-1:0]    out_error_offset,
  output logic [7:0]                           out_error_byte,
  output logic                                 out_buffer_done,
  output logic                                 out_buffer_valid
);

  // Input register: holds the byte being decoded this cycle
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  logic              in_accept;
  logic              s1_move;
  logic              has_result;
  logic              out_ready;
  utfv_pkg::result_t dec_result;
  utfv_pkg::result_t res_q;

  // A byte that makes no result leaves the input register without
  // touching the output side; one that does waits for a free result slot.
  assign s1_move      = s1_valid_r && (!has_result || out_ready);
  assign in_stall     = s1_valid_r && !s1_move;
  assign in_accept    = in_valid && !in_stall;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Decode state advances exactly once per byte, when it leaves the input register
  utfv_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (s1_move),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .has_result (has_result),
    .result     (dec_result)
  );

  // Result register: parts the consumer's stall from the decoder
  utfv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_move && has_result),
    .load_data (dec_result),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_data  (res_q)
  );

  assign out_has_code_point = res_q.has_code_point;
  assign out_code_point     = res_q.code_point;
  assign out_error_now      = res_q.error_now;
  assign out_error_offset   = res_q.error_offset;
  assign out_error_byte     = res_q.error_byte;
  assign out_buffer_done    = res_q.buffer_done;
  assign out_buffer_valid   = res_q.buffer_valid;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && has_result && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_byte_kept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("pending byte lost");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_has_code_point || out_error_now || out_buffer_done)
    else $error("empty result transaction");

endmodule
